// File: sv/qrm_pkg.sv
// Shared types and widths for the quaternion to rotation matrix core.
// Depends on nothing; the core refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package qrm_pkg;

   // Number of matrix entries produced per transfer.
   localparam int ENTRY_COUNT = 9;

   // Width of the squared norm (sum of four squares of 16-bit values).
   localparam int NORM_WIDTH = 33;

   // Width of a signed numerator before the magnitude is taken.
   localparam int NUM_WIDTH = 34;

   // One Q1.14 style matrix entry.
   typedef logic signed [15:0] entry_type;

   // Signed numerator of one entry.
   typedef logic signed [NUM_WIDTH-1:0] num_type;

   // Unsigned norm, numerator magnitude or division remainder.
   typedef logic [NORM_WIDTH-1:0] norm_type;

endpackage

`default_nettype wire

// File: sv/quaternion_to_rotation_matrix_core.sv
// Quaternion to 3x3 rotation matrix core with exact normalizing division.
// Depends on qrm_pkg for widths and entry types.
// One transfer is taken every cycle.
// The depth is set by the restoring divider, one quotient bit per stage, FRAC_BITS + 2 stages.
// Synchronous reset clears only the valid bits; busy is always low and results cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_rotation_matrix_core #(
   parameter int FRAC_BITS = 14
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_start,
   output logic               busy,
   input  wire signed [15:0]  req_quat_w,
   input  wire signed [15:0]  req_quat_x,
   input  wire signed [15:0]  req_quat_y,
   input  wire signed [15:0]  req_quat_z,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_r0c0,
   output logic signed [15:0] rsp_r1c0,
   output logic signed [15:0] rsp_r2c0,
   output logic signed [15:0] rsp_r0c1,
   output logic signed [15:0] rsp_r1c1,
   output logic signed [15:0] rsp_r2c1,
   output logic signed [15:0] rsp_r0c2,
   output logic signed [15:0] rsp_r1c2,
   output logic signed [15:0] rsp_r2c2,
   output logic               rsp_zero_input
);

   localparam int NE = qrm_pkg::ENTRY_COUNT;
   localparam int NW = qrm_pkg::NORM_WIDTH;
   localparam int SW = qrm_pkg::NUM_WIDTH;
   // Quotient bits of 2 * |num| * 2^FRAC_BITS / n, which never exceeds 2^(FRAC_BITS + 1).
   localparam int DIV_STAGES = FRAC_BITS + 2;
   localparam int QX = 33;
   localparam int ONE_SAT = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);

   // The core never stalls the requester.
   assign busy = 1'b0;

   // Stage 1: the ten products.
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;
   logic               v1_ff;

   always_ff @(posedge clock) begin
      ww_ff <= req_quat_w * req_quat_w;
      xx_ff <= req_quat_x * req_quat_x;
      yy_ff <= req_quat_y * req_quat_y;
      zz_ff <= req_quat_z * req_quat_z;
      xy_ff <= req_quat_x * req_quat_y;
      zw_ff <= req_quat_z * req_quat_w;
      xz_ff <= req_quat_x * req_quat_z;
      yw_ff <= req_quat_y * req_quat_w;
      yz_ff <= req_quat_y * req_quat_z;
      xw_ff <= req_quat_x * req_quat_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_start & ~busy;
      end
   end

   // Stage 2: squared norm and the nine signed numerators.
   qrm_pkg::num_type  num_in [NE];
   qrm_pkg::num_type  num_ff [NE];
   qrm_pkg::norm_type n2_in, n2_ff;
   logic              v2_ff;
   qrm_pkg::num_type  sw, sx, sy, sz, sxy, szw, sxz, syw, syz, sxw;

   always_comb begin
      sw  = SW'(ww_ff);
      sx  = SW'(xx_ff);
      sy  = SW'(yy_ff);
      sz  = SW'(zz_ff);
      sxy = SW'(xy_ff);
      szw = SW'(zw_ff);
      sxz = SW'(xz_ff);
      syw = SW'(yw_ff);
      syz = SW'(yz_ff);
      sxw = SW'(xw_ff);
      n2_in = NW'(ww_ff[30:0]) + NW'(xx_ff[30:0]) + NW'(yy_ff[30:0]) + NW'(zz_ff[30:0]);
      num_in[0] = sw + sx - sy - sz;
      num_in[1] = (sxy + szw) <<< 1;
      num_in[2] = (sxz - syw) <<< 1;
      num_in[3] = (sxy - szw) <<< 1;
      num_in[4] = sw - sx + sy - sz;
      num_in[5] = (syz + sxw) <<< 1;
      num_in[6] = (sxz + syw) <<< 1;
      num_in[7] = (syz - sxw) <<< 1;
      num_in[8] = sw - sx - sy + sz;
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      n2_ff  <= n2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   // Divider pipeline arrays; index 0 is loaded by the magnitude stage.
   qrm_pkg::norm_type     rem_ff  [DIV_STAGES+1][NE];
   logic [DIV_STAGES-1:0] quo_ff  [DIV_STAGES+1][NE];
   logic [NE-1:0]         neg_ff  [DIV_STAGES+1];
   qrm_pkg::norm_type     nd_ff   [DIV_STAGES+1];
   logic                  zero_ff [DIV_STAGES+1];
   logic                  vd_ff   [DIV_STAGES+1];

   // Stage 3: sign and magnitude of every numerator, zero norm detect.
   always_ff @(posedge clock) begin
      for (int k = 0; k < NE; k++) begin
         neg_ff[0][k] <= num_ff[k][SW-1];
         rem_ff[0][k] <= num_ff[k][SW-1] ? NW'(-num_ff[k]) : NW'(num_ff[k]);
         quo_ff[0][k] <= '0;
      end
      nd_ff[0]   <= n2_ff;
      zero_ff[0] <= (n2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff[0] <= 1'b0;
      end else begin
         vd_ff[0] <= v2_ff;
      end
   end

   // Restoring division, one quotient bit per stage for all nine entries.
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      logic [NW:0]       trial  [NE];
      logic              qbit   [NE];
      qrm_pkg::norm_type rem_in [NE];

      always_comb begin
         for (int k = 0; k < NE; k++) begin
            trial[k]  = (j == 0) ? {1'b0, rem_ff[j][k]} : {rem_ff[j][k], 1'b0};
            qbit[k]   = trial[k] >= {1'b0, nd_ff[j]};
            rem_in[k] = qbit[k] ? NW'(trial[k] - {1'b0, nd_ff[j]}) : NW'(trial[k]);
         end
      end

      always_ff @(posedge clock) begin
         for (int k = 0; k < NE; k++) begin
            rem_ff[j+1][k] <= rem_in[k];
            quo_ff[j+1][k] <= {quo_ff[j][k][DIV_STAGES-2:0], qbit[k]};
         end
         neg_ff[j+1]  <= neg_ff[j];
         nd_ff[j+1]   <= nd_ff[j];
         zero_ff[j+1] <= zero_ff[j];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[j+1] <= 1'b0;
         end else begin
            vd_ff[j+1] <= vd_ff[j];
         end
      end
   end

   // Final stage: round half away from zero, clamp to one, restore sign; a zero norm gives the identity.
   qrm_pkg::entry_type ent_in [NE];
   qrm_pkg::entry_type ent_ff [NE];
   logic [DIV_STAGES:0] rsum  [NE];
   logic [QX-1:0]       qmag  [NE];
   logic [15:0]         qsat  [NE];
   logic                zout_ff;
   logic                vout_ff;

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         rsum[k] = {1'b0, quo_ff[DIV_STAGES][k]} + (DIV_STAGES+1)'(1);
         qmag[k] = QX'(rsum[k][DIV_STAGES:1]);
         qsat[k] = (qmag[k] > QX'(ONE_SAT)) ? 16'(ONE_SAT) : qmag[k][15:0];
         if (zero_ff[DIV_STAGES]) begin
            ent_in[k] = ((k == 0) || (k == 4) || (k == 8)) ? 16'(ONE_SAT) : '0;
         end else begin
            ent_in[k] = neg_ff[DIV_STAGES][k] ? -$signed(qsat[k]) : $signed(qsat[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      zout_ff <= zero_ff[DIV_STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else begin
         vout_ff <= vd_ff[DIV_STAGES];
      end
   end

   assign rsp_valid      = vout_ff;
   assign rsp_zero_input = zout_ff;
   assign rsp_r0c0       = ent_ff[0];
   assign rsp_r1c0       = ent_ff[1];
   assign rsp_r2c0       = ent_ff[2];
   assign rsp_r0c1       = ent_ff[3];
   assign rsp_r1c1       = ent_ff[4];
   assign rsp_r2c1       = ent_ff[5];
   assign rsp_r0c2       = ent_ff[6];
   assign rsp_r1c2       = ent_ff[7];
   assign rsp_r2c2       = ent_ff[8];

   // A zero quaternion yields the identity matrix.
   a_zero_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_input) |->
         (rsp_r0c0 == 16'(ONE_SAT) && rsp_r1c1 == 16'(ONE_SAT) && rsp_r2c2 == 16'(ONE_SAT)
          && rsp_r1c0 == '0 && rsp_r0c1 == '0 && rsp_r2c1 == '0))
      else $error("zero quaternion did not give the identity");

   // Entries r0c0 and r1c0 stay within plus or minus one (r0c0 is bounded above only by 32767).
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_r0c0 <= 16'sd32767 && $signed(rsp_r0c0) >= -ONE_SAT
                     && $signed(rsp_r1c0) <= ONE_SAT && $signed(rsp_r1c0) >= -ONE_SAT))
      else $error("matrix entry outside the saturation range");

   // The last divider remainder of entry 0 is below the divisor for a nonzero norm.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (vd_ff[DIV_STAGES] && !zero_ff[DIV_STAGES]) |->
         (rem_ff[DIV_STAGES][0] < nd_ff[DIV_STAGES]))
      else $error("divider remainder not below the norm");

   // The core never refuses a transfer.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for quaternion_to_rotation_matrix_core.
// Depends on qrm_pkg and the core; predicts each rotation matrix from the quaternion.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

   localparam int FRAC = 14;
   localparam int LATENCY = FRAC + 6;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_COUNT = 750;

   // Sender idle modes for the phases of the random part; IDLE_NONE serves two phases.
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_LIGHT} idle_mode_type;

   typedef struct packed {
      qrm_pkg::entry_type [8:0] entry;
      logic zero_flag;
   } matrix_type;

   typedef struct {
      logic signed [15:0] w, x, y, z;
      bit has_typed;
      matrix_type typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_start = 1'b0;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic busy, rsp_valid, rsp_zero_input;
   qrm_pkg::entry_type rsp_r0c0, rsp_r1c0, rsp_r2c0, rsp_r0c1, rsp_r1c1, rsp_r2c1;
   qrm_pkg::entry_type rsp_r0c2, rsp_r1c2, rsp_r2c2;

   matrix_type pending_matrices[$];
   int error_count = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   quaternion_to_rotation_matrix_core #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset), .req_start(req_start), .busy(busy),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .rsp_valid(rsp_valid),
      .rsp_r0c0(rsp_r0c0), .rsp_r1c0(rsp_r1c0), .rsp_r2c0(rsp_r2c0),
      .rsp_r0c1(rsp_r0c1), .rsp_r1c1(rsp_r1c1), .rsp_r2c1(rsp_r2c1),
      .rsp_r0c2(rsp_r0c2), .rsp_r1c2(rsp_r1c2), .rsp_r2c2(rsp_r2c2),
      .rsp_zero_input(rsp_zero_input)
   );

   // Rounded, saturated quotient num * 2^FRAC / norm with ties away from zero.
   function automatic qrm_pkg::entry_type scaled_quotient(longint num, longint norm);
      longint mag, q, one;
      one = (FRAC >= 15) ? 32767 : (64'sd1 << FRAC);
      mag = (num < 0) ? -num : num;
      q = (2 * (mag << FRAC) + norm) / (2 * norm);
      if (q > one) q = one;
      return 16'((num < 0) ? -q : q);
   endfunction

   // Rotation matrix of the quaternion scaled to unit length.
   function automatic matrix_type rotation_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                              logic signed [15:0] qy, logic signed [15:0] qz);
      longint w, x, y, z, ww, xx, yy, zz, norm;
      matrix_type m;
      w = longint'(qw); x = longint'(qx); y = longint'(qy); z = longint'(qz);
      ww = w * w; xx = x * x; yy = y * y; zz = z * z;
      norm = ww + xx + yy + zz;
      m = '0;
      if (norm == 0) begin
         m.entry[0] = 16'sd16384;
         m.entry[4] = 16'sd16384;
         m.entry[8] = 16'sd16384;
         m.zero_flag = 1'b1;
      end else begin
         m.entry[0] = scaled_quotient(ww + xx - yy - zz, norm);
         m.entry[1] = scaled_quotient(2 * (x * y + z * w), norm);
         m.entry[2] = scaled_quotient(2 * (x * z - y * w), norm);
         m.entry[3] = scaled_quotient(2 * (x * y - z * w), norm);
         m.entry[4] = scaled_quotient(ww - xx + yy - zz, norm);
         m.entry[5] = scaled_quotient(2 * (y * z + x * w), norm);
         m.entry[6] = scaled_quotient(2 * (x * z + y * w), norm);
         m.entry[7] = scaled_quotient(2 * (y * z - x * w), norm);
         m.entry[8] = scaled_quotient(ww - xx - yy + zz, norm);
      end
      return m;
   endfunction

   // Compare each result transfer with the oldest pending matrix.
   always @(posedge clock) begin
      matrix_type got, want;
      if (!reset && rsp_valid) begin
         got.entry = {rsp_r2c2, rsp_r1c2, rsp_r0c2, rsp_r2c1, rsp_r1c1, rsp_r0c1,
                      rsp_r2c0, rsp_r1c0, rsp_r0c0};
         got.zero_flag = rsp_zero_input;
         if (pending_matrices.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_matrices.pop_front();
            for (int k = 0; k < 9; k++)
               if (got.entry[k] !== want.entry[k]) begin
                  $display("%0t: entry %0d expected %0d, actual %0d", $time, k,
                           want.entry[k], got.entry[k]);
                  error_count++;
               end
            if (got.zero_flag !== want.zero_flag) begin
               $display("%0t: zero_input expected %b, actual %b", $time,
                        want.zero_flag, got.zero_flag);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Present one quaternion and hold it until the transfer; start stays high.
   task automatic send_quaternion(logic signed [15:0] w, logic signed [15:0] x,
                                  logic signed [15:0] y, logic signed [15:0] z,
                                  bit has_typed, matrix_type typed);
      matrix_type predicted;
      predicted = rotation_of(w, x, y, z);
      if (has_typed && predicted !== typed) begin
         $display("%0t: predictor expected %h, actual %h", $time, typed, predicted);
         error_count++;
      end
      req_start <= 1'b1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_matrices.push_back(predicted);
   endtask

   task automatic idle_cycles_gap(idle_mode_type mode);
      int percent;
      percent = (mode == IDLE_SENDER) ? 73 : (mode == IDLE_LIGHT) ? 17 : 0;
      while ($urandom_range(99, 0) < percent) begin
         req_start <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] random_component();
      case ($urandom_range(5, 0))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($signed($urandom_range(64, 0)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      matrix_type identity, flip;
      idle_mode_type mode;
      identity = '0;
      identity.entry[0] = 16'sd16384;
      identity.entry[4] = 16'sd16384;
      identity.entry[8] = 16'sd16384;

      // Directed rows: zero quaternion, unit axes, extremes, mixed signs.
      r = '{w: 0, x: 0, y: 0, z: 0, has_typed: 1, typed: identity};
      r.typed.zero_flag = 1'b1;
      rows.push_back(r);
      r = '{w: 16384, x: 0, y: 0, z: 0, has_typed: 1, typed: identity};
      rows.push_back(r);
      r = '{w: -32768, x: 0, y: 0, z: 0, has_typed: 1, typed: identity};
      rows.push_back(r);
      r = '{w: 1, x: 0, y: 0, z: 0, has_typed: 1, typed: identity};
      rows.push_back(r);
      // A half turn about x negates rows 1 and 2 of the diagonal.
      flip = identity;
      flip.entry[4] = -16'sd16384;
      flip.entry[8] = -16'sd16384;
      r = '{w: 0, x: 32767, y: 0, z: 0, has_typed: 1, typed: flip};
      rows.push_back(r);
      r = '{w: 0, x: 0, y: -32768, z: 0, has_typed: 0, typed: '0};
      rows.push_back(r);
      r = '{w: 0, x: 0, y: 0, z: 16384, has_typed: 0, typed: '0};
      rows.push_back(r);
      r = '{w: -32768, x: -32768, y: -32768, z: -32768, has_typed: 0, typed: '0};
      rows.push_back(r);
      r = '{w: 32767, x: 32767, y: 32767, z: 32767, has_typed: 0, typed: '0};
      rows.push_back(r);
      r = '{w: 32767, x: -32768, y: 32767, z: -32768, has_typed: 0, typed: '0};
      rows.push_back(r);
      r = '{w: 11585, x: 11585, y: 0, z: 0, has_typed: 0, typed: '0};
      rows.push_back(r);
      r = '{w: 1, x: -1, y: 1, z: -1, has_typed: 0, typed: '0};
      rows.push_back(r);
      r = '{w: 0, x: 1, y: 1, z: 0, has_typed: 0, typed: '0};
      rows.push_back(r);
      r = '{w: -1, x: 0, y: 0, z: 32767, has_typed: 0, typed: '0};
      rows.push_back(r);
      r = '{w: 3, x: 5, y: -7, z: 11, has_typed: 0, typed: '0};
      rows.push_back(r);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_quaternion(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                         rows[i].has_typed, rows[i].typed);

      // Random part in idle phases; pause for a full drain before the last phase.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: mode = IDLE_SENDER;
            2: mode = IDLE_LIGHT;
            default: mode = IDLE_NONE;
         endcase
         if (phase == 3) begin
            req_start <= 1'b0;
            while (pending_matrices.size() != 0) @(posedge clock);
         end
         repeat (RANDOM_COUNT / 4) begin
            idle_cycles_gap(mode);
            send_quaternion(random_component(), random_component(),
                            random_component(), random_component(), 0, '0);
         end
      end
      req_start <= 1'b0;

      // Drain, then let the pipeline settle in case of stray results.
      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
sv/qrm_pkg.sv
sv/quaternion_to_rotation_matrix_core.sv
tb/tb_top.sv
